FILE: rtl/jkie_pkg.sv
// jkie_pkg: shared types, character constants and value-parser step functions
// for the keyed integer extractor. No dependencies.
package jkie_pkg;

    localparam int unsigned KEY_BITS = 128;

    // config register indexes
    localparam logic [2:0] CFG_KEY_LO  = 3'd0;
    localparam logic [2:0] CFG_KEY_HI  = 3'd1;
    localparam logic [2:0] CFG_KEY_LEN = 3'd2;
    localparam logic [2:0] CFG_DFLT    = 3'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_F     = 8'h66;

    localparam logic [31:0] SAT_MAG = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        PH_SEARCH, PH_SKIP, PH_TRUE, PH_FALSE, PH_NUMBER, PH_DONE
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  lit_pos;
        logic [31:0] mag;
        logic        neg;
        logic [31:0] held_value;
        logic        held_found;
    } t_vp;

    // setup sequencer -> datapath
    typedef struct packed {
        logic       busy;
        logic       load;
        logic [4:0] eff_len;
    } t_setup_ctl;

    localparam t_vp VP_RESET = '{PH_SEARCH, 3'd0, 32'd0, 1'b0, 32'd0, 1'b0};
    localparam t_vp VP_SKIP  = '{PH_SKIP, 3'd0, 32'd0, 1'b0, 32'd0, 1'b0};

    function automatic logic [7:0] key_byte(input logic [KEY_BITS-1:0] key,
                                            input logic [4:0] idx);
        logic [7:0] b;
        b = key[8*idx[3:0] +: 8];
        return idx[4] ? CH_NUL : b;
    endfunction

    // characters of "true" / "false" by position
    function automatic logic [7:0] lit_char(input logic is_false, input logic [2:0] pos);
        logic [7:0] c;
        c = CH_NUL;
        if (is_false) begin
            unique case (pos)
                3'd0: c = 8'h66;
                3'd1: c = 8'h61;
                3'd2: c = 8'h6C;
                3'd3: c = 8'h73;
                3'd4: c = 8'h65;
                default: c = CH_NUL;
            endcase
        end else begin
            unique case (pos)
                3'd0: c = 8'h74;
                3'd1: c = 8'h72;
                3'd2: c = 8'h75;
                3'd3: c = 8'h65;
                default: c = CH_NUL;
            endcase
        end
        return c;
    endfunction

    function automatic t_vp vp_decide(input t_vp st, input logic [31:0] v, input logic f);
        t_vp r;
        r = st;
        r.held_value = v;
        r.held_found = f;
        r.phase      = PH_DONE;
        return r;
    endfunction

    function automatic logic [31:0] vp_number(input t_vp st);
        logic [31:0] v;
        if (st.neg)
            v = st.mag[31] ? SAT_MAG : (32'd0 - st.mag);
        else
            v = st.mag[31] ? POS_MAX : st.mag;
        return v;
    endfunction

    // mag*10 + d, saturating at 2^31
    function automatic logic [31:0] vp_add_digit(input logic [31:0] mag, input logic [3:0] d);
        logic [35:0] m;
        m = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {32'd0, d};
        return (m > {4'd0, SAT_MAG}) ? SAT_MAG : m[31:0];
    endfunction

    function automatic t_vp vp_finish(input t_vp st, input logic [31:0] dflt);
        t_vp r;
        r = st;
        if (st.phase == PH_NUMBER)
            r = vp_decide(st, vp_number(st), 1'b1);
        else if (st.phase != PH_DONE)
            r = vp_decide(st, dflt, 1'b0);
        return r;
    endfunction

    // one byte of value parsing after the key match
    function automatic t_vp vp_step(input t_vp st, input logic [7:0] b,
                                    input logic [31:0] dflt);
        t_vp        r;
        logic       digit;
        logic [3:0] d;
        logic [7:0] diff;
        r     = st;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        diff  = b - CH_ZERO;
        d     = diff[3:0];
        unique case (st.phase)
            PH_SKIP: begin
                if (b != CH_SPACE) begin
                    r.lit_pos = 3'd1;
                    r.mag     = 32'd0;
                    r.neg     = 1'b0;
                    priority if (b == CH_T) begin
                        r.phase = PH_TRUE;
                    end else if (b == CH_F) begin
                        r.phase = PH_FALSE;
                    end else if (b == CH_MINUS) begin
                        r.neg   = 1'b1;
                        r.phase = PH_NUMBER;
                    end else if (digit) begin
                        r.mag   = {28'd0, d};
                        r.phase = PH_NUMBER;
                    end else begin
                        r = vp_decide(r, dflt, 1'b0);
                    end
                end
            end
            PH_TRUE: begin
                if (st.lit_pos < 3'd4 && b == lit_char(1'b0, st.lit_pos)) begin
                    r.lit_pos = st.lit_pos + 3'd1;
                    if (r.lit_pos == 3'd4) r = vp_decide(r, 32'd1, 1'b1);
                end else begin
                    r = vp_decide(r, dflt, 1'b0);
                end
            end
            PH_FALSE: begin
                if (st.lit_pos < 3'd5 && b == lit_char(1'b1, st.lit_pos)) begin
                    r.lit_pos = st.lit_pos + 3'd1;
                    if (r.lit_pos == 3'd5) r = vp_decide(r, 32'd0, 1'b1);
                end else begin
                    r = vp_decide(r, dflt, 1'b0);
                end
            end
            PH_NUMBER: begin
                if (digit) r.mag = vp_add_digit(st.mag, d);
                else       r = vp_decide(st, vp_number(st), 1'b1);
            end
            default: r = st;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/jkie_cell.sv
// jkie_cell: one byte of the sliding match window with its own pattern byte.
// Depends on jkie_pkg.
module jkie_cell import jkie_pkg::*; #(
    parameter int unsigned IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [4:0]          i_eff_len,
    input  logic                i_shift,
    input  logic                i_clear,
    input  logic [7:0]          i_byte,
    output logic [7:0]          o_byte,
    output logic                o_match
);

    logic [7:0] r_byte;
    logic [7:0] r_pat;
    logic       r_use;
    logic [7:0] n_pat;
    logic       n_use;
    logic [6:0] key_idx;
    logic [6:0] len_ext;

    // cell 0 sees the newest byte: pattern reads backwards from the colon
    always_comb begin
        len_ext = {2'b00, i_eff_len};
        key_idx = len_ext + 7'd1 - 7'(IDX);
        n_use   = 7'(IDX) <= len_ext + 7'd2;
        if (IDX == 0)
            n_pat = CH_COLON;
        else if (IDX == 1 || 7'(IDX) == len_ext + 7'd2)
            n_pat = CH_QUOTE;
        else
            n_pat = key_byte(i_key, key_idx[4:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pat <= n_pat;
            r_use <= n_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_byte <= 8'd0;
        end else if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte  = r_byte;
    assign o_match = !r_use || (i_byte == r_pat);

endmodule

FILE: rtl/jkie_setup.sv
// jkie_setup: after reset or a config write, finds the effective key length,
// loads the cell patterns and replays the key tail after an embedded colon.
// Depends on jkie_pkg.
module jkie_setup import jkie_pkg::*; #(
    parameter int unsigned MAX_KEY_BYTES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [4:0]          i_key_len,
    input  logic [31:0]         i_dflt,
    output t_setup_ctl          o_ctl,
    output t_vp                 o_hit_state
);

    typedef enum logic [1:0] {ST_IDLE, ST_LEN, ST_LOAD, ST_REPLAY} t_state;

    t_state     r_state;
    logic [4:0] r_eff_len;
    logic       r_colon;
    logic [4:0] r_pos;
    t_vp        r_hit;

    logic [4:0] eff;
    logic       colon;
    logic [4:0] colon_pos;
    logic [7:0] replay_byte;

    always_comb begin
        eff       = 5'd16;
        colon     = 1'b0;
        colon_pos = 5'd0;
        for (int i = 15; i >= 0; i--) begin
            if (i >= MAX_KEY_BYTES || 5'(i) >= i_key_len || i_key[8*i +: 8] == CH_NUL)
                eff = 5'(i);
        end
        for (int i = 15; i >= 0; i--) begin
            if (5'(i) < eff && i_key[8*i +: 8] == CH_COLON) begin
                colon     = 1'b1;
                colon_pos = 5'(i);
            end
        end
    end

    // key tail, then the closing quote and colon
    always_comb begin
        if (r_pos < r_eff_len)       replay_byte = key_byte(i_key, r_pos);
        else if (r_pos == r_eff_len) replay_byte = CH_QUOTE;
        else                         replay_byte = CH_COLON;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LEN;
        end else if (i_cfg_we) begin
            r_state <= ST_LEN;
        end else begin
            unique case (r_state)
                ST_IDLE: ;
                ST_LEN: begin
                    r_eff_len <= eff;
                    r_colon   <= colon;
                    r_pos     <= colon_pos + 5'd1;
                    r_state   <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_hit   <= VP_SKIP;
                    r_state <= r_colon ? ST_REPLAY : ST_IDLE;
                end
                ST_REPLAY: begin
                    r_hit <= vp_step(r_hit, replay_byte, i_dflt);
                    r_pos <= r_pos + 5'd1;
                    if (r_pos == r_eff_len + 5'd1) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ctl.busy    = (r_state != ST_IDLE);
    assign o_ctl.load    = (r_state == ST_LOAD);
    assign o_ctl.eff_len = r_eff_len;
    assign o_hit_state   = r_hit;

endmodule

FILE: rtl/json_keyed_int_extractor_unit.sv
// json_keyed_int_extractor_unit: top level. Row of jkie_cell match cells,
// jkie_setup sequencer, value parser and output register. Depends on jkie_pkg.
//
//  channel   dir  handshake               payload
//  s stream  in   i_s_tvalid/o_s_tready   tdata[7:0] text_byte, tlast last_byte
//  m stream  out  o_m_tvalid/i_m_tready   tdata[31:0] value, tuser[0] found
//  cfg       in   i_cfg_we                i_cfg_addr index, i_cfg_data value
//
// One byte per cycle while o_s_tready is high; the result word appears the cycle
// after the last byte. With the setup sequencer idle, the single output register
// lets a new byte in whenever the held result is being taken or none is held.
// After reset and each config write the setup sequencer holds o_s_tready low
// in its length and load states, and in tail replay when the key holds a colon.
// Reset is synchronous, active low.
module json_keyed_int_extractor_unit import jkie_pkg::*; #(
    parameter int unsigned MAX_KEY_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] value
    output logic        o_m_tuser,   // [0] found
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_data
);

    localparam int unsigned WIN = MAX_KEY_BYTES + 3;

    logic [63:0] r_key_lo;
    logic [63:0] r_key_hi;
    logic [4:0]  r_key_len;
    logic [31:0] r_dflt;

    t_vp         r_st;
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic        r_out_found;

    t_setup_ctl  setup_ctl;
    t_vp         hit_state;
    t_vp         st_step;
    t_vp         st_res;
    logic        accept;
    logic        do_shift;
    logic        hit;
    logic [7:0]  win_q   [WIN];
    logic [WIN-1:0] cell_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo  <= 64'd0;
            r_key_hi  <= 64'd0;
            r_key_len <= 5'd1;
            r_dflt    <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_KEY_LO:  r_key_lo  <= i_cfg_data;
                CFG_KEY_HI:  r_key_hi  <= i_cfg_data;
                CFG_KEY_LEN: r_key_len <= i_cfg_data[4:0];
                CFG_DFLT:    r_dflt    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    jkie_setup #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_key       ({r_key_hi, r_key_lo}),
        .i_key_len   (r_key_len),
        .i_dflt      (r_dflt),
        .o_ctl       (setup_ctl),
        .o_hit_state (hit_state)
    );

    assign o_s_tready = !setup_ctl.busy && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    for (genvar g = 0; g < WIN; g++) begin : g_cell
        jkie_cell #(.IDX(g)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (setup_ctl.load),
            .i_key     ({r_key_hi, r_key_lo}),
            .i_eff_len (setup_ctl.eff_len),
            .i_shift   (accept && do_shift),
            .i_clear   (accept && i_s_tlast),
            .i_byte    ((g == 0) ? i_s_tdata : win_q[(g == 0) ? 0 : g - 1]),
            .o_byte    (win_q[g]),
            .o_match   (cell_match[g])
        );
    end

    assign hit = &cell_match;

    always_comb begin
        st_step  = r_st;
        do_shift = 1'b0;
        if (r_st.phase != PH_DONE) begin
            if (i_s_tdata == CH_NUL) begin
                st_step = vp_finish(r_st, r_dflt);
            end else if (r_st.phase == PH_SEARCH) begin
                do_shift = 1'b1;
                if (hit) st_step = hit_state;
            end else begin
                st_step = vp_step(r_st, i_s_tdata, r_dflt);
            end
        end
        st_res = vp_finish(st_step, r_dflt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= VP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) r_st <= i_s_tlast ? VP_RESET : st_step;
            if (accept && i_s_tlast) begin
                r_out_valid <= 1'b1;
                r_out_value <= st_res.held_value;
                r_out_found <= st_res.held_found;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_found;

endmodule

FILE: rtl/jkie_checker.sv
// jkie_checker: port-level assertions for json_keyed_int_extractor_unit,
// attached by bind. No package dependency.
module jkie_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        i_cfg_we
);

    // a held result that is not taken blocks new bytes
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while result word stalled");

    a_last_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> o_m_tvalid)
        else $error("no result word after last byte");

    a_word_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready && i_s_tlast))
        else $error("result word without a last byte");

    a_cfg_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_s_tready)
        else $error("input ready right after config write");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled result word changed");

endmodule

bind json_keyed_int_extractor_unit jkie_checker u_jkie_checker (.*);
